### sv/btr_pkg.sv
// Shared types, constants and codes of the barycentric triangle rasterizer.
// Used by every module of the block; depends on nothing.
package btr_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_BOX_DEF    = 8;
    localparam int SIZE_LIMIT     = 10;

    localparam int CRD_W  = 13;   // signed pixel coordinate
    localparam int PX_W   = 12;   // clipped pixel coordinate
    localparam int CO_W   = 17;   // edge coefficient
    localparam int EDGE_W = 36;   // edge value
    localparam int WGT_W  = 17;   // barycentric weight, unsigned Q1.16 up to 1.0
    localparam int MUL_A  = 18;
    localparam int MUL_B  = 34;
    localparam int ACC_W  = 52;
    localparam int STEP_W = 5;

    localparam logic signed [31:0] FAR_DEPTH  = -32'sd655360000;
    localparam logic [7:0]         ALPHA_BYTE = 8'hFF;

    localparam logic [STEP_W-1:0] SETUP_LAST = 5'd6;
    localparam logic [STEP_W-1:0] DIV_LAST   = 5'd17;
    localparam logic [STEP_W-1:0] MAC_LAST   = 5'd3;
    localparam logic [STEP_W-1:0] AMB_STEP   = 5'd4;
    localparam logic [STEP_W-1:0] COLOR_LAST = 5'd5;
    localparam logic [1:0]        LANE_LAST  = 2'd2;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH_TEST    = 2'd2;
    localparam logic [1:0] REG_AMBIENCE      = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CHECK, ST_SETUP, ST_DSUM, ST_NORM, ST_PIX,
        ST_DIV, ST_ZMUL, ST_DRD, ST_DCHK, ST_COLOR, ST_EMIT, ST_MARK
    } state_t;

    typedef enum logic [3:0] {
        OP_CLEAR, OP_LOAD, OP_CHECK, OP_SETUP, OP_DSUM, OP_NORM, OP_PIX,
        OP_DIV, OP_ZMUL, OP_DRD, OP_DCHK, OP_COLOR, OP_EMIT, OP_MARK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
        logic [1:0]        lane;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic reject;
        logic d_zero;
        logic covered;
        logic out_free;
        logic last_pix;
    } status_t;

    typedef struct packed {
        logic [8:0] screen_width;
        logic [8:0] screen_height;
        logic       depth_test_enable;
        logic [8:0] ambience;
    } cfg_t;

endpackage

### sv/btr_regs.sv
// Configuration registers of the rasterizer behind an APB-style port.
// Depends on btr_pkg.
module btr_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output btr_pkg::cfg_t       cfg
);
    btr_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width      <= 9'd256;
            cfg_reg.screen_height     <= 9'd256;
            cfg_reg.depth_test_enable <= 1'b1;
            cfg_reg.ambience          <= 9'd256;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                btr_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width      <= pwdata[8:0];
                btr_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height     <= pwdata[8:0];
                btr_pkg::REG_DEPTH_TEST:    cfg_reg.depth_test_enable <= pwdata[0];
                btr_pkg::REG_AMBIENCE:      cfg_reg.ambience          <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            btr_pkg::REG_SCREEN_WIDTH:  prdata = {23'd0, cfg_reg.screen_width};
            btr_pkg::REG_SCREEN_HEIGHT: prdata = {23'd0, cfg_reg.screen_height};
            btr_pkg::REG_DEPTH_TEST:    prdata = {31'd0, cfg_reg.depth_test_enable};
            btr_pkg::REG_AMBIENCE:      prdata = {23'd0, cfg_reg.ambience};
        endcase
    end

endmodule

### sv/btr_ctrl.sv
// Controller state machine of the rasterizer: sequences clear sweep, setup,
// per-pixel division, depth and colour steps. Depends on btr_pkg.
module btr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_command,
    output logic                 s_ready,
    input  btr_pkg::status_t     status,
    output btr_pkg::cmd_t        cmd
);
    btr_pkg::state_t                state_reg, state_next;
    logic [btr_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [1:0]                     lane_reg, lane_next;
    logic                           clr_cmd_reg, clr_cmd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= btr_pkg::ST_CLEAR;
            step_reg    <= '0;
            lane_reg    <= '0;
            clr_cmd_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            lane_reg    <= lane_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg + 5'd1;
        lane_next    = lane_reg;
        clr_cmd_next = clr_cmd_reg;
        unique case (state_reg)
            btr_pkg::ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = clr_cmd_reg ? btr_pkg::ST_MARK : btr_pkg::ST_IDLE;
                end
            end
            btr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next   = s_command ? btr_pkg::ST_CLEAR : btr_pkg::ST_CHECK;
                    clr_cmd_next = s_command;
                end
            end
            btr_pkg::ST_CHECK: begin
                state_next = status.reject ? btr_pkg::ST_MARK : btr_pkg::ST_SETUP;
                step_next  = '0;
            end
            btr_pkg::ST_SETUP: begin
                if (step_reg == btr_pkg::SETUP_LAST) begin
                    state_next = btr_pkg::ST_DSUM;
                end
            end
            btr_pkg::ST_DSUM: state_next = btr_pkg::ST_NORM;
            btr_pkg::ST_NORM: begin
                state_next = status.d_zero ? btr_pkg::ST_MARK : btr_pkg::ST_PIX;
            end
            btr_pkg::ST_PIX: begin
                state_next = status.covered ? btr_pkg::ST_DIV : btr_pkg::ST_EMIT;
                step_next  = '0;
                lane_next  = '0;
            end
            btr_pkg::ST_DIV: begin
                if (step_reg == btr_pkg::DIV_LAST) begin
                    step_next = '0;
                    lane_next = lane_reg + 2'd1;
                    if (lane_reg == btr_pkg::LANE_LAST) begin
                        state_next = btr_pkg::ST_ZMUL;
                    end
                end
            end
            btr_pkg::ST_ZMUL: begin
                if (step_reg == btr_pkg::MAC_LAST) begin
                    state_next = btr_pkg::ST_DRD;
                end
            end
            btr_pkg::ST_DRD: state_next = btr_pkg::ST_DCHK;
            btr_pkg::ST_DCHK: begin
                state_next = btr_pkg::ST_COLOR;
                step_next  = '0;
                lane_next  = '0;
            end
            btr_pkg::ST_COLOR: begin
                if (step_reg == btr_pkg::COLOR_LAST) begin
                    step_next = '0;
                    lane_next = lane_reg + 2'd1;
                    if (lane_reg == btr_pkg::LANE_LAST) begin
                        state_next = btr_pkg::ST_EMIT;
                    end
                end
            end
            btr_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.last_pix ? btr_pkg::ST_IDLE : btr_pkg::ST_PIX;
                end
            end
            btr_pkg::ST_MARK: begin
                if (status.out_free) begin
                    state_next = btr_pkg::ST_IDLE;
                end
            end
            default: state_next = btr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.step = step_reg;
        cmd.lane = lane_reg;
        unique case (state_reg)
            btr_pkg::ST_CLEAR: cmd.op = btr_pkg::OP_CLEAR;
            btr_pkg::ST_IDLE: begin
                cmd.op  = btr_pkg::OP_LOAD;
                s_ready = 1'b1;
            end
            btr_pkg::ST_CHECK: cmd.op = btr_pkg::OP_CHECK;
            btr_pkg::ST_SETUP: cmd.op = btr_pkg::OP_SETUP;
            btr_pkg::ST_DSUM:  cmd.op = btr_pkg::OP_DSUM;
            btr_pkg::ST_NORM:  cmd.op = btr_pkg::OP_NORM;
            btr_pkg::ST_PIX:   cmd.op = btr_pkg::OP_PIX;
            btr_pkg::ST_DIV:   cmd.op = btr_pkg::OP_DIV;
            btr_pkg::ST_ZMUL:  cmd.op = btr_pkg::OP_ZMUL;
            btr_pkg::ST_DRD:   cmd.op = btr_pkg::OP_DRD;
            btr_pkg::ST_DCHK:  cmd.op = btr_pkg::OP_DCHK;
            btr_pkg::ST_COLOR: cmd.op = btr_pkg::OP_COLOR;
            btr_pkg::ST_EMIT:  cmd.op = btr_pkg::OP_EMIT;
            btr_pkg::ST_MARK:  cmd.op = btr_pkg::OP_MARK;
            default:           cmd.op = btr_pkg::OP_LOAD;
        endcase
    end

endmodule

### sv/btr_dpath.sv
// Datapath of the rasterizer: box check, edge setup, shared multiplier and
// divider, depth store, output register. Depends on btr_pkg.
module btr_dpath #(
    parameter int MAX_WIDTH  = btr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = btr_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_BOX    = btr_pkg::MAX_BOX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  btr_pkg::cmd_t     cmd,
    output btr_pkg::status_t  status,
    input  btr_pkg::cfg_t     cfg,
    input  logic [31:0]       s_vert0_xy,
    input  logic signed [31:0] s_vert0_depth,
    input  logic [31:0]       s_vert1_xy,
    input  logic signed [31:0] s_vert1_depth,
    input  logic [31:0]       s_vert2_xy,
    input  logic signed [31:0] s_vert2_depth,
    input  logic [23:0]       s_colour0,
    input  logic [23:0]       s_colour1,
    input  logic [23:0]       s_colour2,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [7:0]        m_pixel_x,
    output logic [7:0]        m_pixel_y,
    output logic [31:0]       m_argb,
    output logic              m_written,
    output logic              m_last
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM   = (MAX_BOX - 1 < btr_pkg::SIZE_LIMIT) ? MAX_BOX - 1
                                                                : btr_pkg::SIZE_LIMIT;
    localparam int CW = btr_pkg::CRD_W;
    localparam int PW = btr_pkg::PX_W;
    localparam int EW = btr_pkg::EDGE_W;
    localparam int QW = btr_pkg::WGT_W;
    localparam int AC = btr_pkg::ACC_W;
    localparam int CO_WL = btr_pkg::CO_W;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_reg;
    logic [AW-1:0]      clr_cnt_reg;

    logic signed [15:0] vx_reg [3];
    logic signed [15:0] vy_reg [3];
    logic signed [31:0] vz_reg [3];
    logic [23:0]        col_reg [3];
    logic signed [15:0] vx_in [3];
    logic signed [15:0] vy_in [3];
    logic signed [31:0] vz_in [3];
    logic [23:0]        col_in [3];

    logic signed [CO_WL-1:0] ca_reg [3];
    logic signed [CO_WL-1:0] cb_reg [3];
    logic signed [EW-1:0]    a16_reg [3];
    logic signed [EW-1:0]    b16_reg [3];
    logic signed [EW-1:0]    e_reg [3];
    logic signed [EW-1:0]    erow_reg [3];
    logic signed [EW-1:0]    d_reg;
    logic [QW-1:0]           w_reg [3];
    logic [EW:0]             rem_reg;
    logic [QW-1:0]           q_reg;
    logic signed [AC-1:0]    p_reg;
    logic signed [AC-1:0]    acc_reg;
    logic [7:0]              chan_reg [3];
    logic                    wr_reg;

    logic [PW-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg, x_reg, y_reg;
    logic [AW-1:0] row_base_reg, addr_reg;

    logic [CW-1:0] w_eff, h_eff;
    logic signed [CW-1:0] bx_min, bx_max, by_min, by_max;
    logic signed [CW:0]   dx_box, dy_box;
    logic [PW-1:0] xmin_c, xmax_c, ymin_c, ymax_c;
    logic          reject_c;

    logic signed [btr_pkg::MUL_A-1:0] mul_a;
    logic signed [btr_pkg::MUL_B-1:0] mul_b;
    logic signed [AC-1:0]             mul_p;
    logic [1:0]  sj, aj, wi;
    logic [btr_pkg::STEP_W-1:0] sm;
    logic signed [17:0] px0, py0;
    logic [7:0]  cbyte;
    logic        ge_d;
    logic [EW:0] rem_sub;
    logic [QW-1:0] q_next;
    logic signed [EW-3:0] z_val;
    logic signed [EW-3:0] st_ext;
    logic        wr_now;
    logic [7:0]  sat8;
    logic        out_free;
    logic        last_pix;

    localparam int IA [3] = '{1, 2, 0};
    localparam int IB [3] = '{2, 0, 1};

    function automatic logic signed [CW-1:0] tr16(input logic signed [15:0] v);
        logic signed [15:0] t;
        t = v + (v[15] ? 16'sd15 : 16'sd0);
        return {t[15], t[15:4]};
    endfunction

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [1:0] IA_sel(input logic [1:0] j);
        logic [1:0] r;
        unique case (j)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    assign vx_in  = '{$signed(s_vert0_xy[31:16]), $signed(s_vert1_xy[31:16]),
                      $signed(s_vert2_xy[31:16])};
    assign vy_in  = '{$signed(s_vert0_xy[15:0]), $signed(s_vert1_xy[15:0]),
                      $signed(s_vert2_xy[15:0])};
    assign vz_in  = '{s_vert0_depth, s_vert1_depth, s_vert2_depth};
    assign col_in = '{s_colour0, s_colour1, s_colour2};

    // viewport clamp
    always_comb begin
        if (cfg.screen_width == 9'd0) begin
            w_eff = CW'(1);
        end else if (CW'(cfg.screen_width) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(cfg.screen_width);
        end
        if (cfg.screen_height == 9'd0) begin
            h_eff = CW'(1);
        end else if (CW'(cfg.screen_height) > CW'(MAX_HEIGHT)) begin
            h_eff = CW'(MAX_HEIGHT);
        end else begin
            h_eff = CW'(cfg.screen_height);
        end
    end

    // bounding box, reject test and clipping
    always_comb begin
        bx_min = tr16(min3(vx_reg[0], vx_reg[1], vx_reg[2]));
        bx_max = tr16(max3(vx_reg[0], vx_reg[1], vx_reg[2]));
        by_min = tr16(min3(vy_reg[0], vy_reg[1], vy_reg[2]));
        by_max = tr16(max3(vy_reg[0], vy_reg[1], vy_reg[2]));
        dx_box = {bx_max[CW-1], bx_max} - {bx_min[CW-1], bx_min};
        dy_box = {by_max[CW-1], by_max} - {by_min[CW-1], by_min};
        reject_c = (dx_box > (CW+1)'(LIM)) || (dy_box > (CW+1)'(LIM))
                || bx_max[CW-1] || by_max[CW-1]
                || ($signed({bx_min[CW-1], bx_min}) >= $signed({1'b0, w_eff}))
                || ($signed({by_min[CW-1], by_min}) >= $signed({1'b0, h_eff}));
        xmin_c = bx_min[CW-1] ? '0 : bx_min[PW-1:0];
        ymin_c = by_min[CW-1] ? '0 : by_min[PW-1:0];
        xmax_c = ($signed({bx_max[CW-1], bx_max}) >= $signed({1'b0, w_eff}))
               ? PW'(w_eff - CW'(1)) : bx_max[PW-1:0];
        ymax_c = ($signed({by_max[CW-1], by_max}) >= $signed({1'b0, h_eff}))
               ? PW'(h_eff - CW'(1)) : by_max[PW-1:0];
    end

    // shared multiplier operand select
    always_comb begin
        sj    = cmd.step[2:1];
        wi    = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];
        sm    = cmd.step - 5'd1;
        aj    = sm[2:1];
        px0   = {2'b00, xmin_reg, 4'b0000};
        py0   = {2'b00, ymin_reg, 4'b0000};
        unique case (cmd.lane)
            2'd0:    cbyte = col_reg[wi][23:16];
            2'd1:    cbyte = col_reg[wi][15:8];
            default: cbyte = col_reg[wi][7:0];
        endcase
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            btr_pkg::OP_SETUP: begin
                if (cmd.step[0]) begin
                    mul_a = btr_pkg::MUL_A'(cb_reg[sj]);
                    mul_b = btr_pkg::MUL_B'(py0 - 18'(vy_reg[IA_sel(sj)]));
                end else begin
                    mul_a = btr_pkg::MUL_A'(ca_reg[sj]);
                    mul_b = btr_pkg::MUL_B'(px0 - 18'(vx_reg[IA_sel(sj)]));
                end
            end
            btr_pkg::OP_ZMUL: begin
                mul_a = {1'b0, w_reg[wi]};
                mul_b = btr_pkg::MUL_B'(vz_reg[wi]);
            end
            btr_pkg::OP_COLOR: begin
                if (cmd.step == btr_pkg::AMB_STEP) begin
                    mul_a = {9'd0, cfg.ambience};
                    mul_b = acc_reg[btr_pkg::MUL_B-1:0];
                end else begin
                    mul_a = {1'b0, w_reg[wi]};
                    mul_b = {26'd0, cbyte};
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // divider step, depth test and saturation
    always_comb begin
        ge_d    = rem_reg >= {1'b0, d_reg};
        rem_sub = rem_reg - {1'b0, d_reg};
        q_next  = {q_reg[QW-2:0], ge_d};
        z_val   = acc_reg[16 +: EW-2];
        st_ext  = (EW-2)'(rd_reg);
        wr_now  = (z_val[EW-3] || (z_val == '0))
               && (!cfg.depth_test_enable || (z_val >= st_ext));
        sat8    = (|p_reg[AC-1:32]) ? 8'hFF : p_reg[31:24];
        out_free = !m_valid || m_ready;
        last_pix = (x_reg == xmax_reg) && (y_reg == ymax_reg);
        status.reject   = reject_c;
        status.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
        status.d_zero   = (d_reg == '0);
        status.covered  = !e_reg[0][EW-1] && !e_reg[1][EW-1] && !e_reg[2][EW-1];
        status.out_free = out_free;
        status.last_pix = last_pix;
    end

    // depth store
    always_ff @(posedge aclk) begin
        if (cmd.op == btr_pkg::OP_CLEAR) begin
            mem[clr_cnt_reg] <= btr_pkg::FAR_DEPTH;
        end else if ((cmd.op == btr_pkg::OP_DCHK) && wr_now && cfg.depth_test_enable) begin
            mem[addr_reg] <= z_val[31:0];
        end
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.op == btr_pkg::OP_CLEAR) begin
            clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if ((cmd.op == btr_pkg::OP_EMIT || cmd.op == btr_pkg::OP_MARK) && out_free) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= mul_p;
        unique case (cmd.op)
            btr_pkg::OP_LOAD: begin
                vx_reg  <= vx_in;
                vy_reg  <= vy_in;
                vz_reg  <= vz_in;
                col_reg <= col_in;
            end
            btr_pkg::OP_CHECK: begin
                xmin_reg <= xmin_c;
                xmax_reg <= xmax_c;
                ymin_reg <= ymin_c;
                ymax_reg <= ymax_c;
                for (int i = 0; i < 3; i++) begin
                    ca_reg[i]  <= CO_WL'(vy_reg[IA[i]]) - CO_WL'(vy_reg[IB[i]]);
                    cb_reg[i]  <= CO_WL'(vx_reg[IB[i]]) - CO_WL'(vx_reg[IA[i]]);
                    a16_reg[i] <= EW'(CO_WL'(vy_reg[IA[i]]) - CO_WL'(vy_reg[IB[i]])) <<< 4;
                    b16_reg[i] <= EW'(CO_WL'(vx_reg[IB[i]]) - CO_WL'(vx_reg[IA[i]])) <<< 4;
                end
            end
            btr_pkg::OP_SETUP: begin
                if (cmd.step != '0) begin
                    e_reg[aj] <= sm[0] ? e_reg[aj] + EW'(p_reg) : EW'(p_reg);
                end
            end
            btr_pkg::OP_DSUM: begin
                d_reg        <= e_reg[0] + e_reg[1] + e_reg[2];
                erow_reg     <= e_reg;
                x_reg        <= xmin_reg;
                y_reg        <= ymin_reg;
                row_base_reg <= AW'(ymin_reg * w_eff);
                addr_reg     <= AW'(ymin_reg * w_eff + xmin_reg);
            end
            btr_pkg::OP_NORM: begin
                if (d_reg[EW-1]) begin
                    d_reg <= -d_reg;
                    for (int i = 0; i < 3; i++) begin
                        e_reg[i]    <= -e_reg[i];
                        erow_reg[i] <= -erow_reg[i];
                        a16_reg[i]  <= -a16_reg[i];
                        b16_reg[i]  <= -b16_reg[i];
                    end
                end
            end
            btr_pkg::OP_PIX: begin
                wr_reg <= 1'b0;
            end
            btr_pkg::OP_DIV: begin
                if (cmd.step == '0) begin
                    rem_reg <= {1'b0, e_reg[cmd.lane]};
                    q_reg   <= '0;
                end else begin
                    rem_reg <= (ge_d ? rem_sub : rem_reg) << 1;
                    q_reg   <= q_next;
                    if (cmd.step == btr_pkg::DIV_LAST) begin
                        w_reg[cmd.lane] <= q_next;
                    end
                end
            end
            btr_pkg::OP_ZMUL: begin
                if (cmd.step != '0) begin
                    acc_reg <= (cmd.step == 5'd1) ? p_reg : acc_reg + p_reg;
                end
            end
            btr_pkg::OP_DCHK: begin
                wr_reg <= wr_now;
            end
            btr_pkg::OP_COLOR: begin
                if ((cmd.step != '0) && (cmd.step <= btr_pkg::MAC_LAST)) begin
                    acc_reg <= (cmd.step == 5'd1) ? p_reg : acc_reg + p_reg;
                end
                if (cmd.step == btr_pkg::COLOR_LAST) begin
                    chan_reg[cmd.lane] <= sat8;
                end
            end
            btr_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_pixel_x <= x_reg[7:0];
                    m_pixel_y <= y_reg[7:0];
                    m_argb    <= wr_reg ? {btr_pkg::ALPHA_BYTE, chan_reg[0], chan_reg[1],
                                           chan_reg[2]} : 32'd0;
                    m_written <= wr_reg;
                    m_last    <= last_pix;
                    if (x_reg == xmax_reg) begin
                        x_reg        <= xmin_reg;
                        y_reg        <= y_reg + PW'(1);
                        row_base_reg <= row_base_reg + AW'(w_eff);
                        addr_reg     <= row_base_reg + AW'(w_eff) + AW'(xmin_reg);
                        for (int i = 0; i < 3; i++) begin
                            erow_reg[i] <= erow_reg[i] + b16_reg[i];
                            e_reg[i]    <= erow_reg[i] + b16_reg[i];
                        end
                    end else begin
                        x_reg    <= x_reg + PW'(1);
                        addr_reg <= addr_reg + AW'(1);
                        for (int i = 0; i < 3; i++) begin
                            e_reg[i] <= e_reg[i] + a16_reg[i];
                        end
                    end
                end
            end
            btr_pkg::OP_MARK: begin
                if (out_free) begin
                    m_pixel_x <= '0;
                    m_pixel_y <= '0;
                    m_argb    <= '0;
                    m_written <= 1'b0;
                    m_last    <= 1'b1;
                end
            end
            default: begin
                wr_reg <= wr_reg;
            end
        endcase
    end

endmodule

### sv/barycentric_triangle_rasterizer.sv
// Barycentric triangle rasterizer with depth store: one result per box pixel, or a marker
// for a clear command or a rejected triangle. A covered pixel takes three divider passes,
// a depth MAC and a colour MAC on the shared multiplier; an uncovered pixel skips them.
// Clear command and reset: a sweep over all MAX_WIDTH*MAX_HEIGHT depth memory entries,
// one entry a cycle, with no item accepted; registers are writable meanwhile.
// One item at a time; reset is synchronous, active low. Depends on btr_pkg and submodules.
module barycentric_triangle_rasterizer #(
    parameter int MAX_WIDTH  = btr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = btr_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_BOX    = btr_pkg::MAX_BOX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [31:0]       s_vert0_xy,
    input  logic signed [31:0] s_vert0_depth,
    input  logic [31:0]       s_vert1_xy,
    input  logic signed [31:0] s_vert1_depth,
    input  logic [31:0]       s_vert2_xy,
    input  logic signed [31:0] s_vert2_depth,
    input  logic [23:0]       s_colour0,
    input  logic [23:0]       s_colour1,
    input  logic [23:0]       s_colour2,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_pixel_x,
    output logic [7:0]        m_pixel_y,
    output logic [31:0]       m_argb,
    output logic              m_written,
    output logic              m_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    btr_pkg::cfg_t    cfg;
    btr_pkg::cmd_t    cmd;
    btr_pkg::status_t status;

    btr_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
    );

    btr_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_command, .s_ready, .status, .cmd
    );

    btr_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BOX    (MAX_BOX)
    ) u_dpath (
        .aclk, .aresetn, .cmd, .status, .cfg,
        .s_vert0_xy, .s_vert0_depth, .s_vert1_xy, .s_vert1_depth,
        .s_vert2_xy, .s_vert2_depth, .s_colour0, .s_colour1, .s_colour2,
        .m_ready, .m_valid, .m_pixel_x, .m_pixel_y, .m_argb, .m_written, .m_last
    );

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == btr_pkg::OP_CLEAR) |-> !s_ready)
        else $error("item accepted during depth clear sweep");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in work");

    a_written_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_written) |-> (m_argb[31:24] == btr_pkg::ALPHA_BYTE))
        else $error("written pixel without opaque alpha");

endmodule

### verif/barycentric_triangle_rasterizer_tb.sv
// Self-checking testbench for the barycentric triangle rasterizer: random and directed
// triangles through the item channels, register phases over the APB-style port.
// Depends on btr_pkg and the barycentric_triangle_rasterizer top level.
module barycentric_triangle_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              cmd;
        logic [31:0]       xy [3];
        logic signed [31:0] dz [3];
        logic [23:0]       col [3];
    } tri_item_t;

    typedef struct {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] argb;
        logic        written;
        logic        last;
    } pixel_t;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    logic              s_command = 0;
    logic [31:0]       s_vert0_xy = 0, s_vert1_xy = 0, s_vert2_xy = 0;
    logic signed [31:0] s_vert0_depth = 0, s_vert1_depth = 0, s_vert2_depth = 0;
    logic [23:0]       s_colour0 = 0, s_colour1 = 0, s_colour2 = 0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [7:0]        m_pixel_x, m_pixel_y;
    logic [31:0]       m_argb;
    logic              m_written, m_last;
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [3:0]        paddr = 0;
    logic [31:0]       pwdata = 0;
    logic [31:0]       prdata;
    logic              pready;

    barycentric_triangle_rasterizer dut (.*);

    tri_item_t    pending_tris [$];
    tri_item_t    cur_tri;
    pixel_t       expected_pixels [$];
    logic signed [31:0] depth_mem [btr_pkg::MAX_WIDTH_DEF*btr_pkg::MAX_HEIGHT_DEF];
    btr_pkg::cfg_t cfg;
    int           errors = 0;
    bit           no_idle = 0;
    int           send_gap = 0;
    int           recv_hold = 0;

    initial forever #2 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("barycentric_triangle_rasterizer_tb: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int screen_w();
        return cfg.screen_width == 0 ? 1 : (cfg.screen_width > 256 ? 256 : cfg.screen_width);
    endfunction

    function automatic int screen_h();
        return cfg.screen_height == 0 ? 1 : (cfg.screen_height > 256 ? 256 : cfg.screen_height);
    endfunction

    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
        return (ay - by) * px + (bx - ax) * py + ax * by - bx * ay;
    endfunction

    task automatic rasterize(tri_item_t t);
        longint vx [3], vy [3], vz [3], e [3];
        longint unsigned w [3];
        longint wd, ht, xmn, xmx, ymn, ymx, d, dd, zs, z;
        longint unsigned s;
        logic [31:0] argb;
        pixel_t p;
        bit wr;
        int idx;
        if (t.cmd) begin
            foreach (depth_mem[k]) depth_mem[k] = btr_pkg::FAR_DEPTH;
            p = '{0, 0, 0, 0, 1};
            expected_pixels.push_back(p);
            return;
        end
        for (int i = 0; i < 3; i++) begin
            vx[i] = longint'($signed(t.xy[i][31:16]));
            vy[i] = longint'($signed(t.xy[i][15:0]));
            vz[i] = longint'(t.dz[i]);
        end
        wd = screen_w();
        ht = screen_h();
        xmn = vx[0] < vx[1] ? vx[0] : vx[1]; xmn = xmn < vx[2] ? xmn : vx[2];
        xmx = vx[0] > vx[1] ? vx[0] : vx[1]; xmx = xmx > vx[2] ? xmx : vx[2];
        ymn = vy[0] < vy[1] ? vy[0] : vy[1]; ymn = ymn < vy[2] ? ymn : vy[2];
        ymx = vy[0] > vy[1] ? vy[0] : vy[1]; ymx = ymx > vy[2] ? ymx : vy[2];
        xmn = xmn / 16; xmx = xmx / 16; ymn = ymn / 16; ymx = ymx / 16;
        d = edge_fn(vx[1], vy[1], vx[2], vy[2], vx[0], vy[0]);
        if (xmx - xmn > btr_pkg::MAX_BOX_DEF - 1 || ymx - ymn > btr_pkg::MAX_BOX_DEF - 1 ||
            xmx < 0 || ymx < 0 || xmn > wd - 1 || ymn > ht - 1 || d == 0) begin
            p = '{0, 0, 0, 0, 1};
            expected_pixels.push_back(p);
            return;
        end
        if (xmn < 0) xmn = 0;
        if (ymn < 0) ymn = 0;
        if (xmx > wd - 1) xmx = wd - 1;
        if (ymx > ht - 1) ymx = ht - 1;
        for (longint y = ymn; y <= ymx; y++) begin
            for (longint x = xmn; x <= xmx; x++) begin
                e[0] = edge_fn(vx[1], vy[1], vx[2], vy[2], x * 16, y * 16);
                e[1] = edge_fn(vx[2], vy[2], vx[0], vy[0], x * 16, y * 16);
                e[2] = edge_fn(vx[0], vy[0], vx[1], vy[1], x * 16, y * 16);
                dd = d;
                if (dd < 0) begin
                    dd = -dd;
                    for (int i = 0; i < 3; i++) e[i] = -e[i];
                end
                wr = 0;
                argb = 0;
                if (e[0] >= 0 && e[1] >= 0 && e[2] >= 0) begin
                    zs = 0;
                    for (int i = 0; i < 3; i++) begin
                        w[i] = longint'((e[i] * 65536) / dd);
                        zs += longint'(w[i]) * vz[i];
                    end
                    z = zs >>> 16;
                    if (z <= 0) begin
                        wr = 1;
                        if (cfg.depth_test_enable) begin
                            idx = int'(y * wd + x);
                            if (z < longint'(depth_mem[idx])) wr = 0;
                            else depth_mem[idx] = z[31:0];
                        end
                    end
                    if (wr) begin
                        argb[31:24] = btr_pkg::ALPHA_BYTE;
                        for (int k = 0; k < 3; k++) begin
                            s = 0;
                            for (int i = 0; i < 3; i++)
                                s += w[i] * longint'(t.col[i][(16 - 8*k) +: 8]);
                            s = (s * cfg.ambience) >> 24;
                            argb[(16 - 8*k) +: 8] = s > 255 ? 8'hFF : s[7:0];
                        end
                    end
                end
                p = '{x[7:0], y[7:0], argb, wr, (x == xmx && y == ymx)};
                expected_pixels.push_back(p);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) rasterize(cur_tri);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 0;
                end else if (pending_tris.size() > 0) begin
                    cur_tri = pending_tris.pop_front();
                    s_command     <= cur_tri.cmd;
                    s_vert0_xy    <= cur_tri.xy[0];
                    s_vert1_xy    <= cur_tri.xy[1];
                    s_vert2_xy    <= cur_tri.xy[2];
                    s_vert0_depth <= cur_tri.dz[0];
                    s_vert1_depth <= cur_tri.dz[1];
                    s_vert2_depth <= cur_tri.dz[2];
                    s_colour0     <= cur_tri.col[0];
                    s_colour1     <= cur_tri.col[1];
                    s_colour2     <= cur_tri.col[2];
                    s_valid <= 1;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t p;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", m_pixel_x, m_pixel_y);
                errors++;
            end else begin
                p = expected_pixels.pop_front();
                if (m_pixel_x !== p.x) begin
                    $error("pixel_x: expected %0d, got %0d", p.x, m_pixel_x); errors++;
                end
                if (m_pixel_y !== p.y) begin
                    $error("pixel_y: expected %0d, got %0d", p.y, m_pixel_y); errors++;
                end
                if (m_argb !== p.argb) begin
                    $error("argb: expected %h, got %h", p.argb, m_argb); errors++;
                end
                if (m_written !== p.written) begin
                    $error("written: expected %0b, got %0b", p.written, m_written); errors++;
                end
                if (m_last !== p.last) begin
                    $error("last: expected %0b, got %0b", p.last, m_last); errors++;
                end
            end
        end
        if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
            if ($urandom_range(0, 3) == 0) recv_hold = pick_gap();
        end
    end

    function automatic logic [31:0] pack_xy(int x, int y);
        return {x[15:0], y[15:0]};
    endfunction

    function automatic tri_item_t mk_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                         int z0, int z1, int z2,
                                         logic [23:0] c0, logic [23:0] c1, logic [23:0] c2);
        tri_item_t t;
        t.cmd = 0;
        t.xy[0] = pack_xy(x0, y0); t.xy[1] = pack_xy(x1, y1); t.xy[2] = pack_xy(x2, y2);
        t.dz[0] = z0; t.dz[1] = z1; t.dz[2] = z2;
        t.col[0] = c0; t.col[1] = c1; t.col[2] = c2;
        return t;
    endfunction

    function automatic tri_item_t noise_item(logic cmd);
        tri_item_t t;
        t.cmd = cmd;
        for (int i = 0; i < 3; i++) begin
            t.xy[i] = $urandom;
            t.dz[i] = $urandom;
            t.col[i] = $urandom;
        end
        return t;
    endfunction

    function automatic tri_item_t rand_tri();
        tri_item_t t;
        int bx, by, span;
        t = noise_item(0);
        if ($urandom_range(0, 2) == 0) begin
            bx = $urandom_range(0, 5);
            by = $urandom_range(0, 5);
        end else begin
            bx = $urandom_range(0, screen_w() + 3) - 2;
            by = $urandom_range(0, screen_h() + 3) - 2;
        end
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            t.xy[i] = pack_xy(bx * 16 + $urandom_range(0, span * 16 + 15) - 8,
                              by * 16 + $urandom_range(0, span * 16 + 15) - 8);
            if ($urandom_range(0, 7) != 0) t.dz[i] = -$signed({1'b0, $urandom_range(0, 1 << 22)});
        end
        return t;
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            btr_pkg::REG_SCREEN_WIDTH:  cfg.screen_width = val[8:0];
            btr_pkg::REG_SCREEN_HEIGHT: cfg.screen_height = val[8:0];
            btr_pkg::REG_DEPTH_TEST:    cfg.depth_test_enable = val[0];
            btr_pkg::REG_AMBIENCE:      cfg.ambience = val[8:0];
        endcase
    endtask

    task automatic drain();
        while (pending_tris.size() > 0 || s_valid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_phase(int w, int h, int dt, int amb);
        drain();
        apb_write(btr_pkg::REG_SCREEN_WIDTH, w);
        apb_write(btr_pkg::REG_SCREEN_HEIGHT, h);
        apb_write(btr_pkg::REG_DEPTH_TEST, dt);
        apb_write(btr_pkg::REG_AMBIENCE, amb);
    endtask

    task automatic random_tris(int n);
        for (int i = 0; i < n; i++)
            pending_tris.push_back($urandom_range(0, 9) == 0 ? noise_item(0) : rand_tri());
    endtask

    initial begin
        foreach (depth_mem[k]) depth_mem[k] = btr_pkg::FAR_DEPTH;
        cfg = '{9'd256, 9'd256, 1'b1, 9'd256};
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        set_phase(256, 256, 1, 256);

        pending_tris.push_back(noise_item(1));
        pending_tris.push_back(mk_tri(16, 16, 64, 16, 16, 64, -100, -200, -300,
                                      24'hFF0000, 24'h00FF00, 24'h0000FF));
        pending_tris.push_back(mk_tri(16, 16, 16, 64, 64, 16, -1000000, -1000000, -1000000,
                                      24'h123456, 24'h789ABC, 24'hDEF012));
        pending_tris.push_back(mk_tri(16, 16, 64, 16, 16, 64, -10, -10, -10,
                                      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pending_tris.push_back(mk_tri(100, 100, 140, 100, 100, 140, 65536, 65536, 65536,
                                      24'hFFFFFF, 24'h808080, 24'h010101));
        pending_tris.push_back(mk_tri(0, 0, 160, 0, 0, 16, -5, -5, -5, 0, 0, 0));
        pending_tris.push_back(mk_tri(-48, 16, -40, 32, -33, 0, -5, -5, -5, 0, 0, 0));
        pending_tris.push_back(mk_tri(16, -48, 32, -40, 0, -33, -5, -5, -5, 0, 0, 0));
        pending_tris.push_back(mk_tri(4320, 16, 4330, 40, 4350, 0, -5, -5, -5, 0, 0, 0));
        pending_tris.push_back(mk_tri(16, 4320, 40, 4330, 0, 4350, -5, -5, -5, 0, 0, 0));
        pending_tris.push_back(mk_tri(0, 0, 32, 32, 64, 64, -5, -5, -5,
                                      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pending_tris.push_back(mk_tri(-8, -8, 40, 0, 0, 40, -50, -60, -70,
                                      24'hA0B0C0, 24'h0A0B0C, 24'h556677));
        begin
            tri_item_t t;
            t = mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0, 24'hFFFFFF);
            t.xy[0] = 32'h7FFF7FFF; t.xy[1] = 32'h80008000; t.xy[2] = 32'h00000000;
            t.dz[0] = 32'sh80000000; t.dz[1] = 32'sh7FFFFFFF;
            pending_tris.push_back(t);
        end
        pending_tris.push_back(mk_tri(160, 160, 200, 170, 170, 210, 32'h80000000,
                                      32'h7FFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pending_tris.push_back(mk_tri(0, 0, 112, 0, 0, 112, -20, -30, -40,
                                      24'h000000, 24'hFF00FF, 24'h00FF00));
        pending_tris.push_back(mk_tri(8, 8, 100, 20, 20, 100, -30, -20, -15,
                                      24'h102030, 24'h405060, 24'h708090));
        random_tris(35);

        no_idle = 1;
        set_phase(0, 511, 0, 511);
        random_tris(40);

        no_idle = 0;
        set_phase(20, 12, 1, 0);
        pending_tris.push_back(noise_item(1));
        random_tris(40);

        set_phase(256, 1, 1, 300);
        random_tris(20);
        set_phase(256, 256, 1, 256);
        random_tris(20);

        drain();
        if (errors == 0)
            $display("barycentric_triangle_rasterizer_tb: PASS");
        else
            $display("barycentric_triangle_rasterizer_tb: FAIL");
        $finish;
    end
endmodule

### sim.f
sv/btr_pkg.sv
sv/btr_regs.sv
sv/btr_ctrl.sv
sv/btr_dpath.sv
sv/barycentric_triangle_rasterizer.sv
verif/barycentric_triangle_rasterizer_tb.sv
